FILE: design/eviction_candidate_scorer_assert.svh
// Assertion macros shared by the eviction candidate scorer RTL
`ifndef EVICTION_CANDIDATE_SCORER_ASSERT_SVH
`define EVICTION_CANDIDATE_SCORER_ASSERT_SVH
`ifndef SYNTH
`define ECS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("ecs assertion failed");
`define ECS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("ecs assertion failed");
`else
`define ECS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ECS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: design/ecs_pkg.sv
// Types, constants and tables shared by the eviction candidate scorer
package ecs_pkg;

  localparam int unsigned DIV_IN_W = 41;
  localparam int unsigned DIV_Y_W  = DIV_IN_W - 2;
  localparam int unsigned DIV_Q_W  = 35;
  localparam int unsigned DIV_LO_W = 20;
  localparam int unsigned DIV_SHIFT = 44;
  localparam logic [39:0] DIV_RECIP = 40'd703687441777;

  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  localparam logic [63:0] TEN_SEC_NS = 64'd10000000000;
  localparam logic [5:0]  BOOST_MAX  = 6'd50;
  localparam logic [7:0]  PCT        = 8'd100;

  localparam logic signed [63:0] RTT_LOSS = 64'sd3000;
  localparam logic signed [63:0] RTT_MID  = 64'sd5000;
  localparam logic signed [63:0] RTT_HIGH = 64'sd10000;
  localparam int unsigned LOSS_PCT = 115;
  localparam logic [7:0] NF_BASE       = 8'd100;
  localparam logic [7:0] NF_MID        = 8'd125;
  localparam logic [7:0] NF_HIGH       = 8'd150;
  localparam logic [7:0] NF_BASE_LOSSY = 8'((100 * LOSS_PCT) / 100);
  localparam logic [7:0] NF_MID_LOSSY  = 8'((125 * LOSS_PCT) / 100);
  localparam logic [7:0] NF_HIGH_LOSSY = 8'((150 * LOSS_PCT) / 100);
  localparam logic [6:0] SAT_HIGH = 7'd91;
  localparam logic [6:0] SAT_LOW  = 7'd71;
  localparam logic [7:0] NF_SAT_HIGH_ADD = 8'd10;
  localparam logic [7:0] NF_SAT_LOW_ADD  = 8'd5;

  localparam logic signed [63:0] HOT_MAX  = 64'sd1000000000;
  localparam logic signed [63:0] COLD_MIN = 64'sd10000000000;
  localparam logic [35:0] HEAT_STEP       = 36'd100;
  localparam logic [35:0] LAST_PAGE_BONUS = 36'd100000;
  localparam logic [63:0] SCORE_BLOCKED   = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic blocked;
    logic hot;
    logic cold;
  } ecs_side_t;

  // 50 - secs*50/9 for whole seconds beyond the first
  function automatic logic [5:0] boost_of(input logic [3:0] secs);
    logic [5:0] b;
    case (secs)
      4'd0: b = 6'd50;
      4'd1: b = 6'd45;
      4'd2: b = 6'd39;
      4'd3: b = 6'd34;
      4'd4: b = 6'd28;
      4'd5: b = 6'd23;
      4'd6: b = 6'd17;
      4'd7: b = 6'd12;
      4'd8: b = 6'd6;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

endpackage

FILE: design/ecs_div100.sv
// Two-stage truncating divide by one hundred using a split reciprocal product
module ecs_div100
  import ecs_pkg::*;
(
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic [DIV_IN_W-1:0] x,
  output logic [DIV_Q_W-1:0]  q
);

  localparam int unsigned YH_W = DIV_Y_W - DIV_LO_W;
  localparam int unsigned MH_W = 40 - DIV_LO_W;
  localparam int unsigned P_W  = DIV_Y_W + 40;

  logic [DIV_Y_W-1:0]          y;
  logic [DIV_LO_W-1:0]         ml;
  logic [MH_W-1:0]             mh;
  logic [DIV_LO_W+DIV_LO_W-1:0] pp_ll_r;
  logic [DIV_LO_W+MH_W-1:0]    pp_lh_r;
  logic [YH_W+DIV_LO_W-1:0]    pp_hl_r;
  logic [YH_W+MH_W-1:0]        pp_hh_r;
  logic [P_W-1:0]              prod;
  logic [DIV_Q_W-1:0]          q_r;

  assign y  = x[DIV_IN_W-1:2];
  assign ml = DIV_RECIP[DIV_LO_W-1:0];
  assign mh = DIV_RECIP[39:DIV_LO_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll_r <= (DIV_LO_W+DIV_LO_W)'(y[DIV_LO_W-1:0]) * (DIV_LO_W+DIV_LO_W)'(ml);
      pp_lh_r <= (DIV_LO_W+MH_W)'(y[DIV_LO_W-1:0]) * (DIV_LO_W+MH_W)'(mh);
      pp_hl_r <= (YH_W+DIV_LO_W)'(y[DIV_Y_W-1:DIV_LO_W]) * (YH_W+DIV_LO_W)'(ml);
      pp_hh_r <= (YH_W+MH_W)'(y[DIV_Y_W-1:DIV_LO_W]) * (YH_W+MH_W)'(mh);
    end
  end

  assign prod = (P_W'(pp_hh_r) << (2 * DIV_LO_W))
              + ((P_W'(pp_lh_r) + P_W'(pp_hl_r)) << DIV_LO_W)
              + P_W'(pp_ll_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q_r <= prod[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT];
    end
  end

  assign q = q_r;

endmodule

FILE: design/ecs_net_factor.sv
// Two-stage network factor from RTT, loss and window saturation
module ecs_net_factor
  import ecs_pkg::*;
(
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic signed [63:0] srtt,
  input  logic signed [63:0] lost,
  input  logic signed [63:0] inflight,
  input  logic signed [63:0] cwnd,
  output logic [7:0]         nf
);

  logic [63:0] p_nxt, p_r;
  logic [70:0] c_high_nxt, c_high_r;
  logic [70:0] c_low_nxt, c_low_r;
  logic        sat_nxt, sat_r;
  logic [7:0]  nfb_nxt, nfb_r;
  logic        lossy;
  logic [7:0]  nf_nxt, nf_r;

  always_comb begin
    lossy      = (lost > 64'sd0) && (srtt > RTT_LOSS);
    p_nxt      = inflight * 64'd100;
    c_high_nxt = 71'(unsigned'(cwnd)) * 71'(SAT_HIGH);
    c_low_nxt  = 71'(unsigned'(cwnd)) * 71'(SAT_LOW);
    sat_nxt    = (cwnd > 64'sd0) && (inflight > 64'sd0);
    if (srtt > RTT_HIGH) begin
      nfb_nxt = lossy ? NF_HIGH_LOSSY : NF_HIGH;
    end else if (srtt > RTT_MID) begin
      nfb_nxt = lossy ? NF_MID_LOSSY : NF_MID;
    end else begin
      nfb_nxt = lossy ? NF_BASE_LOSSY : NF_BASE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r      <= p_nxt;
      c_high_r <= c_high_nxt;
      c_low_r  <= c_low_nxt;
      sat_r    <= sat_nxt;
      nfb_r    <= nfb_nxt;
    end
  end

  always_comb begin
    nf_nxt = nfb_r;
    if (sat_r && (71'(p_r) >= c_high_r)) begin
      nf_nxt = nfb_r + NF_SAT_HIGH_ADD;
    end else if (sat_r && (71'(p_r) >= c_low_r)) begin
      nf_nxt = nfb_r + NF_SAT_LOW_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      nf_r <= nf_nxt;
    end
  end

  assign nf = nf_r;

endmodule

FILE: design/ecs_last_page.sv
// Three-stage check that a page is the last page of its file
module ecs_last_page
  import ecs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [63:0] file_bytes,
  input  logic [63:0] page_no,
  input  logic        eligible,
  output logic        last
);

  localparam int unsigned PB_W = $clog2(PAGE_BYTES + 1);
  localparam int unsigned PP_W = 32 + PB_W;
  localparam int unsigned KP_W = 64 + PB_W;
  localparam logic [PB_W-1:0] PB = PB_W'(PAGE_BYTES);

  logic [63:0]      k;
  logic [63:0]      s_r, s2_r;
  logic [PP_W-1:0]  pl_r, ph_r;
  logic             elig_r, elig2_r;
  logic [KP_W-1:0]  kp_r;
  logic [KP_W-1:0]  s_ext;
  logic [KP_W-1:0]  diff;
  logic             last_r;

  assign k = page_no + 64'd1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_r    <= file_bytes + 64'(PAGE_BYTES - 1);
      pl_r   <= PP_W'(k[31:0]) * PP_W'(PB);
      ph_r   <= PP_W'(k[63:32]) * PP_W'(PB);
      elig_r <= eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      kp_r    <= (KP_W'(ph_r) << 32) + KP_W'(pl_r);
      s2_r    <= s_r;
      elig2_r <= elig_r;
    end
  end

  assign s_ext = KP_W'(s2_r);
  assign diff  = s_ext - kp_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      last_r <= elig2_r && (kp_r <= s_ext) && (diff < KP_W'(PB));
    end
  end

  assign last = last_r;

endmodule

FILE: design/eviction_candidate_scorer.sv
// Eviction candidate scorer: takes one candidate beat per cycle while in_stall is low
// and returns its score from a registered output that holds under output stall. The
// pipeline holds the recency multiply, the net factor multiply and the two reciprocal
// divide-by-100 units of two stages each; stages only hold where a stalled beat sits ahead,
// so bubbles close up under output stall. Blocked pages score the maximum signed value.
`include "eviction_candidate_scorer_assert.svh"
module eviction_candidate_scorer
  import ecs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_blocked,
  input  logic [31:0]        in_hit_count,
  input  logic [63:0]        in_age_ns,
  input  logic signed [63:0] in_gap_avg,
  input  logic signed [63:0] in_srtt_smoothed,
  input  logic signed [63:0] in_peak_loss,
  input  logic signed [63:0] in_inflight_smoothed,
  input  logic signed [63:0] in_cwnd_smoothed,
  input  logic [63:0]        in_file_bytes,
  input  logic [63:0]        in_page_no,
  input  logic               in_index_page_eligible,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_score
);

  localparam int unsigned NUM_STAGES = 8;

  logic [NUM_STAGES+1:1] rdy;
  logic [NUM_STAGES:1]   en;
  logic [NUM_STAGES:1]   valid_nxt, valid_r;

  logic [3:0]          secs;
  logic [5:0]          boost_nxt, boost_r;
  logic [31:0]         ac_r;
  ecs_side_t           side_nxt;
  ecs_side_t           side_r [1:7];
  logic [39:0]         m1_r;
  logic [7:0]          nf;
  logic [7:0]          nfc_r [3:4];
  logic                lp_last;
  logic                lastc_r [4:7];
  logic [DIV_Q_W-1:0]  q1, q2;
  logic [DIV_IN_W-1:0] m2_r;
  logic [35:0]         sc;
  logic [63:0]         score_nxt, out_score_r;

  always_comb begin
    rdy[NUM_STAGES+1] = !out_stall;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
    en = rdy[NUM_STAGES:1];
    valid_nxt[1] = en[1] ? in_valid : valid_r[1];
    for (int k = 2; k <= NUM_STAGES; k++) begin
      valid_nxt[k] = en[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall = !en[1];

  always_comb begin
    secs = '0;
    for (int j = 0; j < 8; j++) begin
      if (in_age_ns >= NS_PER_SEC * 64'(j + 2)) begin
        secs = secs + 4'd1;
      end
    end
    if (in_age_ns < NS_PER_SEC) begin
      boost_nxt = BOOST_MAX;
    end else if (in_age_ns >= TEN_SEC_NS) begin
      boost_nxt = '0;
    end else begin
      boost_nxt = boost_of(secs);
    end
    side_nxt.blocked = in_blocked;
    side_nxt.hot     = (in_gap_avg > 64'sd0) && (in_gap_avg < HOT_MAX);
    side_nxt.cold    = in_gap_avg > COLD_MIN;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      boost_r   <= boost_nxt;
      ac_r      <= in_hit_count;
      side_r[1] <= side_nxt;
    end
    for (int k = 2; k <= 7; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m1_r <= 40'(ac_r) * 40'(PCT + 8'(boost_r));
    end
  end

  ecs_net_factor u_net (
    .clk      (clk),
    .en       ({en[2], en[1]}),
    .srtt     (in_srtt_smoothed),
    .lost     (in_peak_loss),
    .inflight (in_inflight_smoothed),
    .cwnd     (in_cwnd_smoothed),
    .nf       (nf)
  );

  ecs_last_page #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_last (
    .clk        (clk),
    .en         ({en[3], en[2], en[1]}),
    .file_bytes (in_file_bytes),
    .page_no    (in_page_no),
    .eligible   (in_index_page_eligible),
    .last       (lp_last)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      nfc_r[3] <= nf;
    end
    if (en[4]) begin
      nfc_r[4]   <= nfc_r[3];
      lastc_r[4] <= lp_last;
    end
    for (int k = 5; k <= 7; k++) begin
      if (en[k]) begin
        lastc_r[k] <= lastc_r[k-1];
      end
    end
  end

  ecs_div100 u_div_base (
    .clk (clk),
    .en  ({en[4], en[3]}),
    .x   (DIV_IN_W'(m1_r)),
    .q   (q1)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m2_r <= DIV_IN_W'(q1[32:0]) * DIV_IN_W'(nfc_r[4]);
    end
  end

  ecs_div100 u_div_net (
    .clk (clk),
    .en  ({en[7], en[6]}),
    .x   (m2_r),
    .q   (q2)
  );

  always_comb begin
    sc = 36'(q2);
    if (side_r[7].hot) begin
      sc = sc + HEAT_STEP;
    end else if (side_r[7].cold && (sc > HEAT_STEP)) begin
      sc = sc - HEAT_STEP;
    end
    if (lastc_r[7]) begin
      sc = sc + LAST_PAGE_BONUS;
    end
    score_nxt = side_r[7].blocked ? SCORE_BLOCKED : 64'(sc);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_score_r <= score_nxt;
    end
  end

  assign out_valid = valid_r[NUM_STAGES];
  assign out_score = out_score_r;

  `ECS_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall, &valid_r)
  `ECS_ASSERT_IMPL(a_score_in_range, clk, rst_n, out_valid && (out_score_r != SCORE_BLOCKED), out_score_r[63:36] == '0)
  `ECS_ASSERT_NEXT(a_last_stage_loads, clk, rst_n, valid_r[7] && en[8], valid_r[8])

endmodule
